// ----- rtl/core/sfe_pkg.sv -----
package sfe_pkg;

   // Delay store depth; must be a power of two so that pointers wrap by truncation.
   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int FRAC_W   = 14;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0]   gain_type;
   typedef logic [ADDR_W-1:0]          addr_type;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ECHO_DELAY    = 2'd0,
      CSR_INPUT_GAIN    = 2'd1,
      CSR_FEEDBACK_GAIN = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [15:0] ECHO_DELAY_RST    = 16'd22050;
   localparam gain_type    INPUT_GAIN_RST    = 16'sd8192;
   localparam gain_type    FEEDBACK_GAIN_RST = 16'sd8192;

   function automatic sample_type sat16_17(input logic signed [SAMPLE_W:0] v);
      sample_type r;
      if (v > 17'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -17'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/stereo_feedback_echo.sv -----
// Stage 1 (store read) feeds the output register and holds while the output stalls;
// no new input is accepted while stage 1 holds an item. The delay store has a single
// write port (read at accept, write-back from stage 2, forwarded to the next read).
// Reset (synchronous, active high) clears the pointer and control state and loads the
// register defaults; a clearing pass then zeroes the store, during which no input is
// accepted. Configuration writes are taken at any time.
module stereo_feedback_echo
   import sfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] left_in, [31:16] right_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [15:0] left_out, [31:16] right_out
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   // configuration
   logic [15:0] echo_delay_ff;
   gain_type    input_gain_ff;
   gain_type    feedback_gain_ff;

   // control
   logic     clearing_ff;
   addr_type clr_addr_ff;
   addr_type ptr_ff;

   // stage 1: waiting for store read data
   logic       s1_valid_ff;
   sample_type s1_left_ff;
   sample_type s1_right_ff;
   addr_type   s1_waddr_ff;
   logic       s1_fwd_ff;
   sample_type s1_fwd_data_ff;

   // stage 2: products, write-back
   logic                 s2_valid_ff;
   addr_type             s2_waddr_ff;
   logic signed [32:0]   s2_prod_in_ff;
   logic signed [31:0]   s2_prod_fb_ff;

   // output register
   logic       rsp_valid_ff;
   sample_type rsp_left_ff;
   sample_type rsp_right_ff;

   // store
   sample_type delay_store [STORE_DEPTH];
   sample_type mem_rd_ff;

   logic       req_accept;
   logic       s1_advance;
   sample_type echo;
   sample_type left_in;
   sample_type right_in;
   logic signed [SAMPLE_W:0] sum_in;
   logic signed [33:0]       acc;
   logic signed [33:0]       acc_biased;
   logic signed [19:0]       quot;
   sample_type               wdata;
   logic                     mem_we;
   addr_type                 mem_waddr;
   sample_type               mem_wdata;
   addr_type                 ptr_in;

   assign left_in  = req_tdata[15:0];
   assign right_in = req_tdata[31:16];

   assign req_tready = !clearing_ff && !s1_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign ptr_in     = ptr_ff + addr_type'(1);

   assign echo   = s1_fwd_ff ? s1_fwd_data_ff : mem_rd_ff;
   assign sum_in = {s1_left_ff[SAMPLE_W-1], s1_left_ff} + {s1_right_ff[SAMPLE_W-1], s1_right_ff};

   // Q2.14 scale: add both products, then divide by 2^14 truncating toward zero
   assign acc        = 34'(s2_prod_in_ff) + 34'(s2_prod_fb_ff);
   assign acc_biased = acc + (acc[33] ? 34'sd16383 : 34'sd0);
   assign quot       = acc_biased[33:FRAC_W];

   always_comb begin
      if (quot > 20'sd32767) begin
         wdata = 16'sh7fff;
      end else if (quot < -20'sd32768) begin
         wdata = 16'sh8000;
      end else begin
         wdata = quot[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s2_valid_ff;
         mem_waddr = s2_waddr_ff;
         mem_wdata = wdata;
      end
   end

   // store: one write and one read port, registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_store[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rd_ff <= delay_store[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_delay_ff    <= ECHO_DELAY_RST;
         input_gain_ff    <= INPUT_GAIN_RST;
         feedback_gain_ff <= FEEDBACK_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ECHO_DELAY:    echo_delay_ff    <= csr_data;
            CSR_INPUT_GAIN:    input_gain_ff    <= csr_data;
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         ptr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + addr_type'(1);
            if (&clr_addr_ff) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_accept) begin
            ptr_ff <= ptr_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         s2_valid_ff <= s1_advance;
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_left_ff  <= left_in;
         s1_right_ff <= right_in;
         s1_waddr_ff <= ptr_ff + echo_delay_ff[ADDR_W-1:0];
         // a write-back landing on this cell at the same edge is missed by the read
         s1_fwd_ff      <= s2_valid_ff && (s2_waddr_ff == ptr_ff);
         s1_fwd_data_ff <= wdata;
      end
      if (s1_advance) begin
         s2_waddr_ff   <= s1_waddr_ff;
         s2_prod_in_ff <= 33'(sum_in) * 33'(input_gain_ff);
         s2_prod_fb_ff <= 32'(echo) * 32'(feedback_gain_ff);
         rsp_left_ff   <= sat16_17({s1_left_ff[SAMPLE_W-1], s1_left_ff} + 17'(echo));
         rsp_right_ff  <= sat16_17({s1_right_ff[SAMPLE_W-1], s1_right_ff} + 17'(echo));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff) else $error("accepted transaction not in stage 1");

   a_ptr_step : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ptr_ff == $past(ptr_in)) else $error("read pointer did not advance");

   a_no_wb_while_clear : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !s2_valid_ff) else $error("item in flight during clear");

   a_wb_follows_advance : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> s2_valid_ff && !s1_valid_ff) else $error("write-back not issued");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import sfe_pkg::*;

   typedef struct packed {
      sample_type right;
      sample_type left;
   } stereo_pair_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;   // [15:0] left_in, [31:16] right_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;         // [15:0] left_out, [31:16] right_out
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index  = CSR_ECHO_DELAY;
   logic [15:0]         csr_data   = '0;

   stereo_feedback_echo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Echo model state and register copies
   sample_type  echo_mem [STORE_DEPTH];
   addr_type    read_ptr    = '0;
   logic [15:0] cur_delay   = ECHO_DELAY_RST;
   gain_type    cur_in_gain = INPUT_GAIN_RST;
   gain_type    cur_fb_gain = FEEDBACK_GAIN_RST;

   stereo_pair_type  pending_pairs [$];
   stereo_pair_type  expected_out  [$];
   stereo_pair_type  on_bus;
   stereo_pair_type  got_pair;
   stereo_pair_type  want_pair;
   int          error_count = 0;
   int          send_gap    = 0;
   int          recv_stall  = 0;
   int          holds_asked = 0;
   int          holds_done  = 0;
   bit          quiet       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic sample_type clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return sample_type'(v);
   endfunction

   // Read the echo, write back the mixed feedback sample, emit both channels.
   function automatic void apply_echo(input stereo_pair_type pair);
      sample_type echo;
      addr_type   waddr;
      longint     acc;
      stereo_pair_type outp;
      echo     = echo_mem[read_ptr];
      waddr    = read_ptr + addr_type'(cur_delay);
      read_ptr = read_ptr + addr_type'(1);
      acc = (longint'(pair.left) + longint'(pair.right)) * longint'(cur_in_gain)
          + longint'(echo) * longint'(cur_fb_gain);
      acc = acc / 16384;   // truncates toward zero
      echo_mem[waddr] = clip16(acc);
      outp.left  = clip16(longint'(pair.left) + longint'(echo));
      outp.right = clip16(longint'(pair.right) + longint'(echo));
      expected_out.push_back(outp);
   endfunction

   function automatic sample_type any_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return sample_type'($urandom_range(0, 512) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] any_gain();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'd16384;
         4, 5: return 16'($urandom_range(0, 32768) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] any_delay();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 48));
      endcase
   endfunction

   // Sender: offers queued pairs, predicts on each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_echo(on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               on_bus = pending_pairs.pop_front();
               req_tdata  <= on_bus;
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure, one long hold on request, result checks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pair = rsp_tdata;
            if (expected_out.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want_pair = expected_out.pop_front();
               if (got_pair.left !== want_pair.left) begin
                  $display("%0t: left_out expected %0d, actual %0d",
                           $time, want_pair.left, got_pair.left);
                  error_count++;
               end
               if (got_pair.right !== want_pair.right) begin
                  $display("%0t: right_out expected %0d, actual %0d",
                           $time, want_pair.right, got_pair.right);
                  error_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (holds_done != holds_asked) begin
            holds_done++;
            recv_stall = 299;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_pair(input logic [15:0] l, input logic [15:0] r);
      stereo_pair_type p;
      p.left  = l;
      p.right = r;
      pending_pairs.push_back(p);
   endtask

   task automatic queue_random(input int n);
      stereo_pair_type p;
      repeat (n) begin
         p.left  = any_sample();
         p.right = any_sample();
         pending_pairs.push_back(p);
      end
   endtask

   // Sampled on the falling edge so the sender and receiver have settled.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || expected_out.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ECHO_DELAY:    cur_delay   = val;
         CSR_INPUT_GAIN:    cur_in_gain = val;
         CSR_FEEDBACK_GAIN: cur_fb_gain = val;
         default: ;
      endcase
   endtask

   initial begin
      foreach (echo_mem[i]) echo_mem[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults after reset: store cleared, so no echo yet
      queue_pair(16'h7fff, 16'h7fff);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h0000, 16'hffff);
      queue_pair(16'h7fff, 16'h8000);
      queue_pair(16'haaaa, 16'h5555);
      wait_drained();

      // one-sample delay at full positive gain: echo and outputs saturate
      write_reg(CSR_ECHO_DELAY, 16'd1);
      write_reg(CSR_INPUT_GAIN, 16'h7fff);
      write_reg(CSR_FEEDBACK_GAIN, 16'h7fff);
      @(negedge clock);
      queue_pair(16'h7fff, 16'h7fff);
      queue_pair(16'h7fff, 16'h7fff);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h8000, 16'h7fff);
      queue_pair(16'h0001, 16'hffff);
      queue_pair(16'h0003, 16'h0000);
      queue_pair(16'hfffd, 16'h0000);
      wait_drained();

      // zero delay is a full-depth echo; most negative gains; ignored index
      write_reg(CSR_ECHO_DELAY, 16'd0);
      write_reg(CSR_INPUT_GAIN, 16'h8000);
      write_reg(CSR_FEEDBACK_GAIN, 16'h8000);
      write_reg(CSR_UNUSED, 16'h1234);
      @(negedge clock);
      queue_pair(16'h7fff, 16'h7fff);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h1234, 16'hedcc);
      wait_drained();

      // largest delay wraps the write to the cell behind the read pointer
      write_reg(CSR_ECHO_DELAY, 16'hffff);
      write_reg(CSR_INPUT_GAIN, 16'd16384);
      write_reg(CSR_FEEDBACK_GAIN, 16'h0000);
      @(negedge clock);
      queue_pair(16'h4000, 16'hc000);
      queue_pair(16'h0101, 16'h8080);
      queue_pair(16'hffff, 16'h0001);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_ECHO_DELAY, any_delay());
         write_reg(CSR_INPUT_GAIN, any_gain());
         write_reg(CSR_FEEDBACK_GAIN, any_gain());
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, 16'($urandom));
         @(negedge clock);
         if (ph == 2) holds_asked++;   // long receiver hold while the sender keeps going
         if (ph == 7) quiet = 1'b1;
         queue_random(80);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- stereo_feedback_echo.f -----
rtl/core/sfe_pkg.sv
rtl/core/stereo_feedback_echo.sv
bench/testbench.sv
